### rtl/apn_pkg.sv
// Shared constants for the audio peak normalizer.
// No dependencies; imported by apn_div and audio_peak_normalizer.
`default_nettype none

package apn_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int GAIN_W          = 32;
	localparam int FRAC_BITS       = 15;

	localparam logic [CFG_DATA_W-1:0] TARGET_RESET = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESET_PEAK  = 2'd1;

endpackage

`default_nettype wire

### rtl/apn_div.sv
// Restoring divider for the gain: one quotient bit per cycle.
// Depends on apn_pkg for the quotient width.
`default_nettype none

module apn_div #(
	parameter int DIVISOR_W = apn_pkg::CFG_DATA_W
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [apn_pkg::GAIN_W-1:0]  dividend,
	input  wire logic [DIVISOR_W-1:0]        divisor,
	output logic                             done,
	output logic [apn_pkg::GAIN_W-1:0]       quotient
);
	import apn_pkg::*;

	localparam int CNT_W = $clog2(GAIN_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [GAIN_W-1:0]    quo_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	// Bring down the next dividend bit and try a subtraction.
	assign trial = {rem_q, quo_q[GAIN_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### rtl/audio_peak_normalizer.sv
// Top level of the two-pass audio peak normalizer.
// Depends on apn_pkg and instantiates the gain divider apn_div.
`default_nettype none

// How to use this block:
// Requests arrive on the in_valid / in_ready channel with kind, sample and
// start_over. A measure request (kind = 0) folds the sample's magnitude into
// the running peak, clearing it first when start_over is set; it produces no
// result. A scale request (kind = 1) produces one result on the out_valid /
// out_ready channel: the sample times the gain, rounded, saturated, with
// clipped set when the clamp acted.
// The first scale request after reset or after any measure request recomputes
// the gain with a restoring divider, one quotient bit per cycle, or sets it to
// zero when the peak is zero.
// The product uses one shared SAMPLE_BITS x 17 multiplier in the states
// ST_MUL_LO and ST_MUL_HI (low and high half of the gain), followed by a
// rounding and saturation step in ST_ROUND. The next request is taken in the
// cycle after the result is loaded. The result sits in an output register;
// while the receiver stalls, measure requests are still accepted, and a scale
// request waits in its last step until the output register is free.
// Configuration writes (target_level, preset_peak) are meant for idle times
// and take effect at the next gain computation. Reset sets target_level to
// full scale, clears the preset peak, the running peak and the gain.
module audio_peak_normalizer #(
	parameter int SAMPLE_BITS = apn_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [apn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [apn_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             kind,
	input  wire logic signed [SAMPLE_BITS-1:0]    sample,
	input  wire logic                             start_over,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [SAMPLE_BITS-1:0]         scaled_sample,
	output logic                                  clipped
);
	import apn_pkg::*;

	// Peak select wide enough for either source of the peak.
	localparam int PEAK_W = (SAMPLE_BITS > CFG_DATA_W) ? SAMPLE_BITS : CFG_DATA_W;
	localparam int HALF_W = GAIN_W / 2;
	localparam int PROD_W = SAMPLE_BITS + HALF_W + 1;
	localparam int ACC_W  = SAMPLE_BITS + GAIN_W + 1;
	localparam int RES_W  = ACC_W - FRAC_BITS;
	localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ROUND
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0]         target_q;
	logic [CFG_DATA_W-1:0]         preset_q;
	logic [SAMPLE_BITS-1:0]        running_q;
	logic [GAIN_W-1:0]             gain_q;
	logic                          gain_ready_q;
	logic signed [SAMPLE_BITS-1:0] samp_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_clip_q;

	logic                   in_accept;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS-1:0] peak_base;
	logic [PEAK_W-1:0]      peak_sel;
	logic                   peak_zero;
	logic [GAIN_W-1:0]      dividend;
	logic                   div_start;
	logic                   div_done;
	logic [GAIN_W-1:0]      div_quot;
	logic                   out_free;

	logic [HALF_W-1:0]             mul_b;
	logic signed [PROD_W-1:0]      prod;
	logic signed [ACC_W-1:0]       prod_lo;
	logic signed [ACC_W-1:0]       prod_hi;
	logic signed [ACC_W-1:0]       rnd;
	logic [RES_W-1:0]              res;
	logic [RES_W-SAMPLE_BITS:0]    res_top;
	logic                          ovf;
	logic [SAMPLE_BITS-1:0]        sat_val;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Magnitude of the sample; the most negative code maps to 2^(SAMPLE_BITS-1),
	// which still fits the unsigned register.
	assign mag       = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
	assign peak_base = start_over ? '0 : running_q;

	// A nonzero preset peak overrides the measured one.
	assign peak_sel  = (preset_q != '0) ? PEAK_W'(preset_q) : PEAK_W'(running_q);
	assign peak_zero = (peak_sel == '0);
	// target * 2^15 plus half the peak, so the truncating divide rounds.
	assign dividend  = GAIN_W'({target_q, {FRAC_BITS{1'b0}}}) + GAIN_W'(peak_sel >> 1);
	assign div_start = in_accept && kind && !gain_ready_q && !peak_zero;

	apn_div #(
		.DIVISOR_W(PEAK_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (peak_sel),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Shared multiplier: sample times one 16-bit half of the gain.
	assign mul_b   = (state_q == ST_MUL_LO) ? gain_q[HALF_W-1:0] : gain_q[GAIN_W-1:HALF_W];
	assign prod    = PROD_W'(samp_q) * PROD_W'($signed({1'b0, mul_b}));
	assign prod_lo = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign prod_hi = {prod, {HALF_W{1'b0}}};

	// Round half up, then floor by an arithmetic shift.
	assign rnd     = acc_q + $signed(ROUND_BIAS);
	assign res     = rnd[ACC_W-1:FRAC_BITS];
	assign res_top = res[RES_W-1:SAMPLE_BITS-1];
	// The result fits when every bit above the sample's sign bit matches it.
	assign ovf     = !((&res_top) || !(|res_top));
	assign sat_val = res[RES_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
	                              : {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			target_q     <= TARGET_RESET;
			preset_q     <= '0;
			running_q    <= '0;
			gain_q       <= '0;
			gain_ready_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TARGET_LEVEL: target_q <= cfg_wdata;
					REG_PRESET_PEAK:  preset_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (!kind) begin
							running_q    <= (mag > peak_base) ? mag : peak_base;
							gain_ready_q <= 1'b0;
						end else if (gain_ready_q) begin
							state_q <= ST_MUL_LO;
						end else if (peak_zero) begin
							gain_q       <= '0;
							gain_ready_q <= 1'b1;
							state_q      <= ST_MUL_LO;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						gain_q       <= div_quot;
						gain_ready_q <= 1'b1;
						state_q      <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: begin
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			samp_q <= sample;
		end
		if (state_q == ST_MUL_LO) begin
			acc_q <= prod_lo;
		end else if (state_q == ST_MUL_HI) begin
			acc_q <= acc_q + prod_hi;
		end
		if ((state_q == ST_ROUND) && out_free) begin
			out_sample_q <= ovf ? sat_val : res[SAMPLE_BITS-1:0];
			out_clip_q   <= ovf;
		end
	end

	assign out_valid     = out_valid_q;
	assign scaled_sample = out_sample_q;
	assign clipped       = out_clip_q;

endmodule

`default_nettype wire
